[src/skf_pkg.sv]
package skf_pkg;

	localparam int unsigned MEAS_W = 16;
	localparam int unsigned Q_W = 32;
	localparam int unsigned GAIN_W = 17;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [Q_W-1:0] PROCESS_NOISE_RST = 32'd655;
	localparam logic [Q_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
	localparam logic [Q_W-1:0] VARIANCE_RST = 32'd32768;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PRED = 7'b0000010,
		ST_DEN  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MULE = 7'b0010000,
		ST_MULV = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

[src/scalar_kalman_filter.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    measurement
// output    out        out_valid/out_stall  estimate, gain, variance
// config    in         cfg_write            cfg_index, cfg_data
//
// A measurement passes the PRED, DEN, DIV, MULE, MULV and DONE states in turn.
// A 16-step restoring divider produces the gain, one bit a cycle; the single
// shared 18x34 multiplier then forms the estimate and variance products.
// A new measurement is taken only once the sequencer is back in idle.
// A result waits in the output register while out_stall is high; the next
// measurement is still accepted, and its result waits until the slot frees.
// Reset restores the register defaults, a zero estimate and a variance of 0.5.
module scalar_kalman_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [skf_pkg::Q_W-1:0]             cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [skf_pkg::MEAS_W-1:0]   measurement,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [skf_pkg::Q_W-1:0]      estimate,
	output logic [skf_pkg::GAIN_W-1:0]          gain,
	output logic [skf_pkg::Q_W-1:0]             variance
);

	localparam int unsigned QW = skf_pkg::Q_W;
	localparam int unsigned IW = QW + 2;
	localparam int unsigned MAW = skf_pkg::GAIN_W + 1;
	localparam int unsigned PW = MAW + IW;
	localparam int unsigned EW = PW - skf_pkg::FRAC_W;

	skf_pkg::state_t state_q;

	logic [QW-1:0] process_noise_q;
	logic [QW-1:0] measurement_noise_q;
	logic signed [QW-1:0] last_estimate_q;
	logic [QW-1:0] last_variance_q;

	logic signed [skf_pkg::MEAS_W-1:0] meas_q;
	logic [QW-1:0] pred_q;
	logic [QW:0] den_q;
	logic [QW:0] rem_q;
	logic [skf_pkg::DIV_STEPS-1:0] quo_q;
	logic [skf_pkg::CNT_W-1:0] cnt_q;
	logic [skf_pkg::GAIN_W-1:0] gain_q;
	logic signed [IW-1:0] innov_q;
	logic signed [PW-1:0] prod_q;
	logic signed [QW-1:0] est_q;

	logic accept_in;
	logic out_free;
	logic [QW:0] pred_sum;
	logic [QW+1:0] rem_shift;
	logic rem_ge;
	logic signed [MAW-1:0] mul_a;
	logic signed [IW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [EW-1:0] est_sum;

	assign in_stall = (state_q != skf_pkg::ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign pred_sum = {1'b0, last_variance_q} + {1'b0, process_noise_q};
	assign rem_shift = {rem_q, 1'b0};
	assign rem_ge = (rem_shift >= {1'b0, den_q});

	// The one multiplier serves the estimate product, then the variance product.
	always_comb begin
		if (state_q == skf_pkg::ST_MULV) begin
			mul_a = $signed({1'b0, skf_pkg::GAIN_ONE - gain_q});
			mul_b = $signed({2'b00, pred_q});
		end else begin
			mul_a = $signed({2'b00, quo_q});
			mul_b = innov_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	// Arithmetic shift of the product is the floor toward minus infinity.
	assign est_sum = EW'(last_estimate_q) + EW'(prod_q >>> skf_pkg::FRAC_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= skf_pkg::PROCESS_NOISE_RST;
			measurement_noise_q <= skf_pkg::MEASUREMENT_NOISE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				skf_pkg::REG_PROCESS_NOISE: process_noise_q <= cfg_data;
				skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
			out_valid <= 1'b0;
			last_estimate_q <= '0;
			last_variance_q <= skf_pkg::VARIANCE_RST;
			cnt_q <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != skf_pkg::ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				skf_pkg::ST_IDLE: begin
					if (accept_in) begin
						state_q <= skf_pkg::ST_PRED;
					end
				end
				skf_pkg::ST_PRED: begin
					state_q <= skf_pkg::ST_DEN;
				end
				skf_pkg::ST_DEN: begin
					cnt_q <= '0;
					state_q <= skf_pkg::ST_DIV;
				end
				skf_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
						state_q <= skf_pkg::ST_MULE;
					end
				end
				skf_pkg::ST_MULE: begin
					state_q <= skf_pkg::ST_MULV;
				end
				skf_pkg::ST_MULV: begin
					state_q <= skf_pkg::ST_DONE;
				end
				skf_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						last_estimate_q <= est_q;
						last_variance_q <= prod_q[skf_pkg::FRAC_W +: QW];
						state_q <= skf_pkg::ST_IDLE;
					end
				end
				default: state_q <= skf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			meas_q <= measurement;
		end
		unique case (state_q)
			skf_pkg::ST_PRED: begin
				pred_q <= pred_sum[QW] ? {QW{1'b1}} : pred_sum[QW-1:0];
				innov_q <= IW'($signed({meas_q, {skf_pkg::FRAC_W{1'b0}}}))
					- IW'(last_estimate_q);
			end
			skf_pkg::ST_DEN: begin
				den_q <= {1'b0, pred_q} + {1'b0, measurement_noise_q};
				rem_q <= {1'b0, pred_q};
				quo_q <= '0;
			end
			skf_pkg::ST_DIV: begin
				rem_q <= rem_ge ? (QW+1)'(rem_shift - {1'b0, den_q})
					: rem_shift[QW:0];
				quo_q <= {quo_q[skf_pkg::DIV_STEPS-2:0], rem_ge};
			end
			skf_pkg::ST_MULE: begin
				// A zero denominator gives no gain; zero measurement noise gives full gain.
				priority if (den_q == '0) begin
					gain_q <= '0;
					prod_q <= '0;
				end else if (measurement_noise_q == '0) begin
					gain_q <= skf_pkg::GAIN_ONE;
					prod_q <= PW'(innov_q) <<< skf_pkg::FRAC_W;
				end else begin
					gain_q <= {1'b0, quo_q};
					prod_q <= mul_p;
				end
			end
			skf_pkg::ST_MULV: begin
				prod_q <= mul_p;
				priority if (est_sum > EW'(32'sh7fffffff)) begin
					est_q <= 32'sh7fffffff;
				end else if (est_sum < -EW'(33'sh080000000)) begin
					est_q <= 32'sh80000000;
				end else begin
					est_q <= est_sum[QW-1:0];
				end
			end
			skf_pkg::ST_DONE: begin
				if (out_free) begin
					estimate <= est_q;
					gain <= gain_q;
					variance <= prod_q[skf_pkg::FRAC_W +: QW];
				end
			end
			default: ;
		endcase
	end

endmodule

[src/skf_checker.sv]
module skf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [skf_pkg::Q_W-1:0]      estimate,
	input logic [skf_pkg::GAIN_W-1:0]          gain,
	input logic [skf_pkg::Q_W-1:0]             variance
);

	// The sequencer takes one measurement at a time.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a measurement is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(variance))
		else $error("stalled result changed or dropped");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain <= skf_pkg::GAIN_ONE)
		else $error("gain above one");

	// Full gain trusts the measurement entirely, so no error variance remains.
	a_full_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gain == skf_pkg::GAIN_ONE |-> variance == '0)
		else $error("nonzero variance at full gain");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.estimate(estimate),
	.gain(gain),
	.variance(variance)
);
